// ===== rtl/kmk_pkg.sv =====
// Shared types and constants for the keyboard mouse-keys translator.
// No dependencies; used by kmk_div and keyboard_mouse_keys_translator.
`default_nettype none
package kmk_pkg;

  localparam int CODE_W  = 9;
  localparam int VALUE_W = 16;
  localparam int HOLD_W  = 10;
  localparam int THR_W   = 8;
  localparam int STEP_W  = 5;
  localparam int BASE_W  = 4;

  localparam logic [HOLD_W-1:0] HOLD_MAX = 10'd1023;

  // key codes
  localparam logic [CODE_W-1:0] KC_OPTION = 9'd357;
  localparam logic [CODE_W-1:0] KC_UP     = 9'd103;
  localparam logic [CODE_W-1:0] KC_DOWN   = 9'd108;
  localparam logic [CODE_W-1:0] KC_LEFT   = 9'd105;
  localparam logic [CODE_W-1:0] KC_RIGHT  = 9'd106;
  localparam logic [CODE_W-1:0] KC_BTN_A  = 9'd107;
  localparam logic [CODE_W-1:0] KC_BTN_B  = 9'd166;
  localparam logic [CODE_W-1:0] KC_BTN_C  = 9'd200;
  localparam logic [CODE_W-1:0] KC_VOLDN  = 9'd74;
  localparam logic [CODE_W-1:0] KC_VOLUP  = 9'd78;
  localparam logic [CODE_W-1:0] KC_SHIFT  = 9'd42;
  localparam logic [CODE_W-1:0] KC_ALT    = 9'd56;

  // mouse button codes
  localparam logic [CODE_W-1:0] BTN_L = 9'd272;
  localparam logic [CODE_W-1:0] BTN_R = 9'd273;
  localparam logic [CODE_W-1:0] BTN_M = 9'd274;

  // motion axis codes
  localparam logic [CODE_W-1:0] AXIS_X = 9'd0;
  localparam logic [CODE_W-1:0] AXIS_Y = 9'd1;

  // host commands
  localparam logic [CODE_W-1:0] CMD_PLAY    = 9'd0;
  localparam logic [CODE_W-1:0] CMD_STOP    = 9'd1;
  localparam logic [CODE_W-1:0] CMD_KB_DN   = 9'd2;
  localparam logic [CODE_W-1:0] CMD_KB_UP   = 9'd3;
  localparam logic [CODE_W-1:0] CMD_LCD_DN  = 9'd4;
  localparam logic [CODE_W-1:0] CMD_LCD_UP  = 9'd5;

  // key values
  localparam logic [1:0] KV_RELEASE = 2'd0;
  localparam logic [1:0] KV_PRESS   = 2'd1;

  // input kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // config register indexes
  localparam logic REG_STEP_BASE = 1'b0;
  localparam logic REG_ACCEL_THR = 1'b1;

  typedef enum logic [2:0] {
    CLS_KEY  = 3'd0,
    CLS_VERT = 3'd1,
    CLS_HORZ = 3'd2,
    CLS_SYNC = 3'd3,
    CLS_CMD  = 3'd4
  } cls_t;

  // what an accepted item produces
  typedef enum logic [1:0] {
    RK_MOTION,
    RK_KEY,
    RK_CMD
  } res_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/kmk_div.sv =====
// Serial restoring divider for hold_count / accel_threshold, one quotient bit a cycle.
// Depends on kmk_pkg for widths. Zero divisor acts as one.
`default_nettype none
module kmk_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [kmk_pkg::HOLD_W-1:0] dividend,
  input  wire logic [kmk_pkg::THR_W-1:0]  divisor,
  output logic                           done,
  output logic [kmk_pkg::HOLD_W-1:0]      quotient
);

  localparam int STEPS = kmk_pkg::HOLD_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [kmk_pkg::THR_W-1:0]  dvs;
  logic [kmk_pkg::THR_W-1:0]  rem;
  logic [kmk_pkg::THR_W:0]    trial;
  logic                       fits;

  assign trial = {rem, quotient[STEPS-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= (divisor == '0) ? kmk_pkg::THR_W'(1) : divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so the difference fits THR_W bits
      rem      <= fits ? kmk_pkg::THR_W'(trial - {1'b0, dvs}) : trial[kmk_pkg::THR_W-1:0];
      quotient <= {quotient[STEPS-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/keyboard_mouse_keys_translator.sv =====
// Top level of the keyboard mouse-keys translator: decode, state, sequencer, output register.
// Depends on kmk_pkg and kmk_div (serial divider for the acceleration factor).
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+-------------------------------------------
//  in      | in_valid  | in_stall   | kind, key_code, key_value
//  out     | out_valid | out_stall  | out_class, out_code, out_value, last
//  cfg     | cfg_we    | -          | cfg_index, cfg_data
//
// Motion items are accepted, pass through the serial divider and then give
// three output beats. Key and command items are accepted and give
// one or two beats. Ticks with nothing held, or outside mouse mode, give
// no beats. in_stall is high from accept until the last beat is loaded
// into the output register. Reset is synchronous.
`default_nettype none
module keyboard_mouse_keys_translator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [kmk_pkg::THR_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [kmk_pkg::CODE_W-1:0]    key_code,
  input  wire logic [1:0]                    key_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_class,
  output logic [kmk_pkg::CODE_W-1:0]         out_code,
  output logic signed [kmk_pkg::VALUE_W-1:0] out_value,
  output logic                               last
);

  localparam int SW = kmk_pkg::STEP_W;
  localparam int HW = kmk_pkg::HOLD_W;
  localparam int AW = HW + 1;

  // config and state
  logic [kmk_pkg::BASE_W-1:0] step_base;
  logic [kmk_pkg::THR_W-1:0]  accel_threshold;
  logic                       mouse_mode;
  logic                       shift_held;
  logic                       alt_held;
  logic [3:0]                 held;
  logic signed [SW-1:0]       step_x;
  logic signed [SW-1:0]       step_y;
  logic [HW-1:0]              hold_count;

  kmk_pkg::state_t    state, state_next;
  kmk_pkg::res_kind_t res_kind;
  logic [kmk_pkg::CODE_W-1:0] res_code;
  logic [1:0]                 res_val;
  logic [1:0]                 idx, idx_next;

  // decode results
  logic                       mode_n, shift_n, alt_n;
  logic [3:0]                 held_n;
  logic signed [SW-1:0]       sx_n, sy_n;
  logic [HW-1:0]              hold_n;
  logic                       dec_none;
  kmk_pkg::res_kind_t         dec_kind;
  logic [kmk_pkg::CODE_W-1:0] dec_code;
  logic signed [SW-1:0]       sb_pos, sb_neg;

  logic accept, out_free, out_load, div_start, div_done;
  logic [HW-1:0] quotient;

  kmk_pkg::cls_t              r_class;
  logic [kmk_pkg::CODE_W-1:0] r_code;
  logic signed [kmk_pkg::VALUE_W-1:0] r_value;
  logic                       r_last;

  logic [AW-1:0]              acc;
  logic signed [SW-1:0]       step_sel;
  logic signed [16:0]         step_ext, acc_ext;
  logic signed [33:0]         prod;

  assign in_stall = (state != kmk_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign sb_pos = {1'b0, step_base};
  assign sb_neg = -sb_pos;

  // decode of one item against the current state
  always_comb begin
    mode_n   = mouse_mode;
    shift_n  = shift_held;
    alt_n    = alt_held;
    held_n   = held;
    sx_n     = step_x;
    sy_n     = step_y;
    hold_n   = hold_count;
    dec_none = 1'b0;
    dec_kind = kmk_pkg::RK_KEY;
    dec_code = key_code;
    if (kind == kmk_pkg::KIND_TICK) begin
      if (!mouse_mode || held == 4'd0) begin
        dec_none = 1'b1;
      end else begin
        dec_kind = kmk_pkg::RK_MOTION;
        // down overrides up, right overrides left
        if (held[0]) sy_n = sb_neg;
        if (held[1]) sy_n = sb_pos;
        if (held[2]) sx_n = sb_neg;
        if (held[3]) sx_n = sb_pos;
      end
    end else begin
      if (key_code == kmk_pkg::KC_OPTION && key_value == kmk_pkg::KV_PRESS) mode_n = !mouse_mode;
      if (key_code == kmk_pkg::KC_ALT)   alt_n   = (key_value == kmk_pkg::KV_PRESS);
      if (key_code == kmk_pkg::KC_SHIFT) shift_n = (key_value == kmk_pkg::KV_PRESS);
      if (mode_n) begin
        case (key_code)
          kmk_pkg::KC_UP: begin
            dec_kind  = kmk_pkg::RK_MOTION;
            held_n[0] = (key_value == kmk_pkg::KV_PRESS);
            sy_n      = (key_value == kmk_pkg::KV_RELEASE) ? '0 : sb_neg;
          end
          kmk_pkg::KC_DOWN: begin
            dec_kind  = kmk_pkg::RK_MOTION;
            held_n[1] = (key_value == kmk_pkg::KV_PRESS);
            sy_n      = (key_value == kmk_pkg::KV_RELEASE) ? '0 : sb_pos;
          end
          kmk_pkg::KC_LEFT: begin
            dec_kind  = kmk_pkg::RK_MOTION;
            held_n[2] = (key_value == kmk_pkg::KV_PRESS);
            sx_n      = (key_value == kmk_pkg::KV_RELEASE) ? '0 : sb_neg;
          end
          kmk_pkg::KC_RIGHT: begin
            dec_kind  = kmk_pkg::RK_MOTION;
            held_n[3] = (key_value == kmk_pkg::KV_PRESS);
            sx_n      = (key_value == kmk_pkg::KV_RELEASE) ? '0 : sb_pos;
          end
          kmk_pkg::KC_BTN_A: dec_code = kmk_pkg::BTN_M;
          kmk_pkg::KC_BTN_B: dec_code = kmk_pkg::BTN_R;
          kmk_pkg::KC_BTN_C: dec_code = kmk_pkg::BTN_L;
          default: dec_code = key_code;
        endcase
      end else if (key_value == kmk_pkg::KV_PRESS) begin
        if (key_code == kmk_pkg::KC_BTN_C) begin
          dec_kind = kmk_pkg::RK_CMD;
          dec_code = kmk_pkg::CMD_PLAY;
        end else if (key_code == kmk_pkg::KC_BTN_B) begin
          dec_kind = kmk_pkg::RK_CMD;
          dec_code = kmk_pkg::CMD_STOP;
        end else if (key_code == kmk_pkg::KC_VOLDN && (shift_n || alt_n)) begin
          dec_kind = kmk_pkg::RK_CMD;
          dec_code = shift_n ? kmk_pkg::CMD_KB_DN : kmk_pkg::CMD_LCD_DN;
        end else if (key_code == kmk_pkg::KC_VOLUP && (shift_n || alt_n)) begin
          dec_kind = kmk_pkg::RK_CMD;
          dec_code = shift_n ? kmk_pkg::CMD_KB_UP : kmk_pkg::CMD_LCD_UP;
        end
      end
    end
    // hold counter moves only on motion
    if (dec_kind == kmk_pkg::RK_MOTION) begin
      if (held_n != 4'd0 || sx_n != '0 || sy_n != '0) begin
        hold_n = (hold_count == kmk_pkg::HOLD_MAX) ? hold_count : hold_count + 1'b1;
      end else begin
        hold_n = '0;
      end
    end
  end

  // result beat selection
  assign acc      = AW'(quotient) + AW'(1);
  assign step_sel = (idx == 2'd0) ? step_y : step_x;
  assign step_ext = {{(17-SW){step_sel[SW-1]}}, step_sel};
  assign acc_ext  = {{(17-AW){1'b0}}, acc};
  assign prod     = step_ext * acc_ext;

  always_comb begin
    r_class = kmk_pkg::CLS_SYNC;
    r_code  = '0;
    r_value = '0;
    r_last  = 1'b0;
    case (res_kind)
      kmk_pkg::RK_MOTION: begin
        case (idx)
          2'd0: begin
            r_class = kmk_pkg::CLS_VERT;
            r_code  = kmk_pkg::AXIS_Y;
            r_value = prod[kmk_pkg::VALUE_W-1:0];
          end
          2'd1: begin
            r_class = kmk_pkg::CLS_HORZ;
            r_code  = kmk_pkg::AXIS_X;
            r_value = prod[kmk_pkg::VALUE_W-1:0];
          end
          default: r_last = 1'b1;
        endcase
      end
      kmk_pkg::RK_KEY: begin
        if (idx == 2'd0) begin
          r_class = kmk_pkg::CLS_KEY;
          r_code  = res_code;
          r_value = {{(kmk_pkg::VALUE_W-2){1'b0}}, res_val};
        end else begin
          r_last = 1'b1;
        end
      end
      kmk_pkg::RK_CMD: begin
        r_class = kmk_pkg::CLS_CMD;
        r_code  = res_code;
        r_last  = 1'b1;
      end
      default: r_last = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      kmk_pkg::S_IDLE: begin
        idx_next = '0;
        if (accept && !dec_none) begin
          if (dec_kind == kmk_pkg::RK_MOTION) begin
            div_start  = 1'b1;
            state_next = kmk_pkg::S_DIV;
          end else begin
            state_next = kmk_pkg::S_EMIT;
          end
        end
      end
      kmk_pkg::S_DIV: begin
        if (div_done) state_next = kmk_pkg::S_EMIT;
      end
      kmk_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (r_last) begin
            state_next = kmk_pkg::S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = kmk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmk_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_base       <= 4'd3;
      accel_threshold <= 8'd8;
      mouse_mode      <= 1'b0;
      shift_held      <= 1'b0;
      alt_held        <= 1'b0;
      held            <= '0;
      step_x          <= '0;
      step_y          <= '0;
      hold_count      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == kmk_pkg::REG_STEP_BASE) begin
          step_base <= cfg_data[kmk_pkg::BASE_W-1:0];
        end else begin
          accel_threshold <= cfg_data;
        end
      end
      if (accept) begin
        mouse_mode <= mode_n;
        shift_held <= shift_n;
        alt_held   <= alt_n;
        held       <= held_n;
        step_x     <= sx_n;
        step_y     <= sy_n;
        hold_count <= hold_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind <= dec_kind;
      res_code <= dec_code;
      res_val  <= key_value;
    end
  end

  kmk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hold_n),
    .divisor  (accel_threshold),
    .done     (div_done),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class <= r_class;
      out_code  <= r_code;
      out_value <= r_value;
      last      <= r_last;
    end
  end

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == kmk_pkg::S_DIV)
    else $error("divider finished outside the divide wait");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && r_last |=> !in_stall)
    else $error("sequencer did not return to idle after the final beat");

  a_vert_then_horz: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_class == kmk_pkg::CLS_VERT
    |=> out_valid && out_class == kmk_pkg::CLS_HORZ)
    else $error("vertical motion beat not followed by horizontal beat");

endmodule
`default_nettype wire
